// ===== src/c128_pkg.sv =====
// ----------------------------------------------------------------------------
// c128_pkg
// Shared types, constants and functions of the Code 128 module serializer.
// ----------------------------------------------------------------------------
package c128_pkg;

   localparam logic [6:0]  SYM_MAX      = 7'd105;
   localparam logic [6:0]  SYM_MODULUS  = 7'd103;
   localparam logic [6:0]  WEIGHT_LAST  = 7'd102;
   localparam logic [3:0]  SYM_LEN      = 4'd11;
   localparam logic [3:0]  STOP_LEN     = 4'd13;
   localparam logic [12:0] STOP_PATTERN = 13'h18EB;
   localparam int          PROD_W       = 14;

   localparam logic [10:0] SYM_TABLE [0:105] = '{
      11'h6CC, 11'h66C, 11'h666, 11'h498, 11'h48C, 11'h44C, 11'h4C8, 11'h4C4, 11'h464, 11'h648,
      11'h644, 11'h624, 11'h59C, 11'h4DC, 11'h4CE, 11'h5CC, 11'h4EC, 11'h4E6, 11'h672, 11'h65C,
      11'h64E, 11'h6E4, 11'h674, 11'h76E, 11'h74C, 11'h72C, 11'h726, 11'h764, 11'h734, 11'h732,
      11'h6D8, 11'h6C6, 11'h636, 11'h518, 11'h458, 11'h446, 11'h588, 11'h468, 11'h462, 11'h688,
      11'h628, 11'h622, 11'h5B8, 11'h58E, 11'h46E, 11'h5D8, 11'h5C6, 11'h476, 11'h776, 11'h68E,
      11'h62E, 11'h6E8, 11'h6E2, 11'h6EE, 11'h758, 11'h746, 11'h716, 11'h768, 11'h762, 11'h71A,
      11'h77A, 11'h642, 11'h78A, 11'h530, 11'h50C, 11'h4B0, 11'h486, 11'h42C, 11'h426, 11'h590,
      11'h584, 11'h4D0, 11'h4C2, 11'h434, 11'h432, 11'h612, 11'h650, 11'h7BA, 11'h614, 11'h47A,
      11'h53C, 11'h4BC, 11'h49E, 11'h5E4, 11'h4F4, 11'h4F2, 11'h7A4, 11'h794, 11'h792, 11'h6DE,
      11'h6F6, 11'h7B6, 11'h578, 11'h51E, 11'h45E, 11'h5E8, 11'h5E2, 11'h7A8, 11'h7A2, 11'h5DE,
      11'h5EE, 11'h75E, 11'h7AE, 11'h684, 11'h690, 11'h69C
   };

   typedef struct packed {
      logic [6:0] sym;
      logic       first;
      logic       last;
      logic [6:0] check;
   } c128_entry_type;

   // bar/space pattern of a symbol, left aligned in the 13-bit shifter
   function automatic logic [12:0] sym_pattern(input logic [6:0] sym);
      logic [10:0] pat;
      if (sym > SYM_MAX) begin
         pat = SYM_TABLE[SYM_MAX];
      end else begin
         pat = SYM_TABLE[sym];
      end
      return {pat, 2'b00};
   endfunction

   // x mod 103 by folding 128 = 25 (mod 103)
   function automatic logic [6:0] mod103(input logic [PROD_W-1:0] x);
      logic [11:0] f1;
      logic [9:0]  f2;
      logic [7:0]  f3;
      logic [7:0]  r;
      f1 = 12'(x[13:7]) * 12'd25 + 12'(x[6:0]);
      f2 = 10'(f1[11:7]) * 10'd25 + 10'(f1[6:0]);
      f3 = 8'(f2[9:7]) * 8'd25 + 8'(f2[6:0]);
      if (f3 >= 8'd206) begin
         r = f3 - 8'd206;
      end else if (f3 >= 8'(SYM_MODULUS)) begin
         r = f3 - 8'(SYM_MODULUS);
      end else begin
         r = f3;
      end
      return r[6:0];
   endfunction

endpackage

// ===== src/c128_front.sv =====
// ----------------------------------------------------------------------------
// c128_front
// Accepts symbols, saturates them and updates the mod 103 checksum.
// ----------------------------------------------------------------------------
module c128_front import c128_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [6:0]     req_symbol,
   input  logic           req_first,
   input  logic           req_last,
   output logic           push_valid,
   output c128_entry_type push_entry,
   input  logic           push_full
);

   logic              stage_valid_ff, stage_valid_in;
   logic [6:0]        sym_ff;
   logic              first_ff, last_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [6:0]        acc_ff, acc_in;
   logic [6:0]        weight_ff, weight_in;
   logic [6:0]        sym_sat;
   logic [6:0]        red;
   logic              accept, push;

   always_comb begin
      sym_sat = (req_symbol > SYM_MAX) ? SYM_MAX : req_symbol;
      accept  = req_valid && !stage_valid_ff;
      push    = stage_valid_ff && !push_full;
      if (req_first) begin
         prod_in = PROD_W'(sym_sat);
      end else begin
         prod_in = PROD_W'(sym_sat) * PROD_W'(weight_ff) + PROD_W'(acc_ff);
      end
      red = mod103(prod_ff);
      stage_valid_in = accept || (stage_valid_ff && !push);
      acc_in    = acc_ff;
      weight_in = weight_ff;
      if (push) begin
         if (last_ff) begin
            acc_in    = '0;
            weight_in = '0;
         end else begin
            acc_in = red;
            if (first_ff) begin
               weight_in = 7'd1;
            end else if (weight_ff == WEIGHT_LAST) begin
               weight_in = '0;
            end else begin
               weight_in = weight_ff + 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         acc_ff         <= '0;
         weight_ff      <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         acc_ff         <= acc_in;
         weight_ff      <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sym_ff   <= sym_sat;
         first_ff <= req_first;
         last_ff  <= req_last;
         prod_ff  <= prod_in;
      end
   end

   assign req_stall        = stage_valid_ff;
   assign push_valid       = stage_valid_ff;
   assign push_entry.sym   = sym_ff;
   assign push_entry.first = first_ff;
   assign push_entry.last  = last_ff;
   assign push_entry.check = red;

`ifndef SYNTH
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff < SYM_MODULUS) else $error("checksum out of range");
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      weight_ff < SYM_MODULUS) else $error("weight out of range");
   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && push_full) |=> (stage_valid_ff && $stable(prod_ff)))
      else $error("staged transaction lost while queue full");
`endif

endmodule

// ===== src/c128_queue.sv =====
// ----------------------------------------------------------------------------
// c128_queue
// Two-entry queue between the symbol front end and the module serializer.
// ----------------------------------------------------------------------------
module c128_queue import c128_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  c128_entry_type push_entry,
   output logic           push_full,
   input  logic           pop,
   output logic           head_valid,
   output c128_entry_type head_entry
);

   c128_entry_type mem_ff [0:1];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff;
   logic           do_push, do_pop;

   assign push_full  = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/c128_back.sv =====
// ----------------------------------------------------------------------------
// c128_back
// Serializes quiet zones, symbol, check and stop patterns into modules.
// ----------------------------------------------------------------------------
module c128_back import c128_pkg::*; #(
   parameter int QUIET_MODULES = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  c128_entry_type head_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_module_res,
   output logic           rsp_end_of_run
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEAD, PH_SYM, PH_CHK, PH_STP, PH_TRAIL
   } phase_type;

   localparam logic [3:0] QUIET_LEN = 4'(QUIET_MODULES);

   phase_type   phase_ff, phase_in, next_ph, load_ph;
   logic [3:0]  cnt_ff, cnt_in;
   logic [12:0] shift_ff, shift_in;
   logic [6:0]  sym_ff, check_ff;
   logic        last_ff;
   logic        rsp_valid_ff, rsp_module_ff, rsp_eor_ff;
   logic        adv, fire, final_mod, item_done;
   logic [6:0]  ld_sym, ld_check;

   always_comb begin
      adv       = !rsp_valid_ff || !rsp_stall;
      fire      = (phase_ff != PH_IDLE) && adv;
      final_mod = (cnt_ff == 4'd1);
      unique case (phase_ff)
         PH_LEAD:  next_ph = PH_SYM;
         PH_SYM:   next_ph = last_ff ? PH_CHK : PH_IDLE;
         PH_CHK:   next_ph = PH_STP;
         PH_STP:   next_ph = (QUIET_LEN != 4'd0) ? PH_TRAIL : PH_IDLE;
         PH_TRAIL: next_ph = PH_IDLE;
         default:  next_ph = PH_IDLE;
      endcase
      item_done = fire && final_mod && (next_ph == PH_IDLE);
      pop       = head_valid && ((phase_ff == PH_IDLE) || item_done);

      // phase to enter and the operands it loads from
      if (pop) begin
         load_ph  = (head_entry.first && (QUIET_LEN != 4'd0)) ? PH_LEAD : PH_SYM;
         ld_sym   = head_entry.sym;
         ld_check = head_entry.check;
      end else begin
         load_ph  = next_ph;
         ld_sym   = sym_ff;
         ld_check = check_ff;
      end

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (pop || (fire && final_mod)) begin
         phase_in = load_ph;
         unique case (load_ph)
            PH_LEAD, PH_TRAIL: begin
               cnt_in   = QUIET_LEN;
               shift_in = '0;
            end
            PH_SYM: begin
               cnt_in   = SYM_LEN;
               shift_in = sym_pattern(ld_sym);
            end
            PH_CHK: begin
               cnt_in   = SYM_LEN;
               shift_in = sym_pattern(ld_check);
            end
            PH_STP: begin
               cnt_in   = STOP_LEN;
               shift_in = STOP_PATTERN;
            end
            default: begin
               cnt_in   = '0;
               shift_in = '0;
            end
         endcase
      end else if (fire) begin
         cnt_in   = cnt_ff - 4'd1;
         shift_in = {shift_ff[11:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         if (adv) begin
            rsp_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (pop) begin
         sym_ff   <= head_entry.sym;
         check_ff <= head_entry.check;
         last_ff  <= head_entry.last;
      end
      if (fire) begin
         rsp_module_ff <= shift_ff[12];
         rsp_eor_ff    <= final_mod && (next_ph == PH_IDLE);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_module_res = rsp_module_ff;
   assign rsp_end_of_run = rsp_eor_ff;

`ifndef SYNTH
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (cnt_ff != 4'd0)) else $error("empty phase still active");
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_eor_ff) |-> (phase_ff != PH_IDLE))
      else $error("transaction ended without end_of_run");
   a_stop_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STP && $past(phase_ff) != PH_STP) |-> (cnt_ff == STOP_LEN))
      else $error("stop pattern loaded with wrong length");
`endif

endmodule

// ===== src/code128_symbol_to_modules.sv =====
// ----------------------------------------------------------------------------
// code128_symbol_to_modules
// Code 128 symbol values in, serialized bar/space modules out.
// ----------------------------------------------------------------------------
// an accepted symbol passes the front stage, the queue and the serializer registers
// throughput: one module per cycle while rsp_stall is low; a data symbol is 11 modules
// the front end takes no new symbol while its stage holds one; it feeds a 2-entry queue
// a barcode's last symbol adds 24 modules plus the trailing quiet zone
// reset: synchronous, clears queue, phase, checksum and position weight
module code128_symbol_to_modules import c128_pkg::*; #(
   parameter int QUIET_MODULES = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [6:0] req_symbol,
   input  logic       req_first,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_module_res,
   output logic       rsp_end_of_run
);

   logic           push_valid, push_full;
   c128_entry_type push_entry;
   logic           pop, head_valid;
   c128_entry_type head_entry;

   c128_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .req_first  (req_first),
      .req_last   (req_last),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_full  (push_full)
   );

   c128_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_full  (push_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   c128_back #(
      .QUIET_MODULES (QUIET_MODULES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_module_res (rsp_module_res),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

// ===== tb/sv/code128_symbol_to_modules_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// code128_symbol_to_modules_tb
// Drives Code 128 symbol values into the serializer and checks every module
// it emits against a cycle-free model of quiet zones, symbol patterns, the
// weighted checksum and the stop pattern. A short table of directed items is
// followed by random barcodes under several idle and stall mixes, including
// one long output hold that backs up the input side.
// ----------------------------------------------------------------------------
module code128_symbol_to_modules_tb;
   import c128_pkg::*;

   localparam int QUIET       = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCH_LIMIT = 5000;
   localparam int PHASE_ITEMS = 95;

   typedef struct packed {
      logic bar_space;
      logic end_run;
   } module_beat_type;

   typedef struct packed {
      logic [6:0] sym;
      logic       first;
      logic       last;
      logic [7:0] run_len;
   } drive_row_type;

   // run_len is the module count of the transaction, read off the barcode layout
   localparam int N_DIRECTED = 16;
   localparam drive_row_type DIRECTED [N_DIRECTED] = '{
      '{7'd0,   1'b0, 1'b0, 8'd11},
      '{7'd103, 1'b1, 1'b0, 8'd21},
      '{7'd0,   1'b0, 1'b0, 8'd11},
      '{7'd127, 1'b0, 1'b0, 8'd11},
      '{7'd106, 1'b0, 1'b0, 8'd11},
      '{7'd102, 1'b0, 1'b1, 8'd45},
      '{7'd104, 1'b1, 1'b1, 8'd55},
      '{7'd105, 1'b1, 1'b0, 8'd21},
      '{7'd1,   1'b0, 1'b0, 8'd11},
      '{7'd105, 1'b0, 1'b1, 8'd45},
      '{7'd50,  1'b1, 1'b0, 8'd21},
      '{7'd64,  1'b0, 1'b1, 8'd45},
      '{7'd127, 1'b1, 1'b1, 8'd55},
      '{7'd0,   1'b0, 1'b1, 8'd45},
      '{7'd103, 1'b1, 1'b1, 8'd55},
      '{7'd105, 1'b1, 1'b1, 8'd55}
   };

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [6:0] req_symbol     = 7'd0;
   logic       req_first      = 1'b0;
   logic       req_last       = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_module_res;
   logic       rsp_end_of_run;

   module_beat_type module_q [$];
   int              run_len_q [$];
   logic [6:0]      chk_sum    = 7'd0;
   logic [6:0]      pos_weight = 7'd0;
   int              fail_count = 0;
   int              beats_in_run = 0;
   int              items_sent = 0;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   bit              hold_req = 1'b0;

   code128_symbol_to_modules #(.QUIET_MODULES(QUIET)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .req_first      (req_first),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_module_res (rsp_module_res),
      .rsp_end_of_run (rsp_end_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void note_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic void push_pattern(input logic [12:0] pattern, input int len);
      module_beat_type beat;
      for (int i = len - 1; i >= 0; i--) begin
         beat.bar_space = pattern[i];
         beat.end_run   = 1'b0;
         module_q.push_back(beat);
      end
   endfunction

   // expected modules of one accepted transaction
   function automatic void expand_symbol(input logic [6:0] sym, input logic first,
                                         input logic last);
      logic [6:0]      s;
      module_beat_type beat;
      int              acc;
      s = (sym > SYM_MAX) ? SYM_MAX : sym;
      if (first) begin
         push_pattern(13'd0, QUIET);
         chk_sum    = 7'(int'(s) % int'(SYM_MODULUS));
         pos_weight = 7'd1;
      end else begin
         acc        = (int'(chk_sum) + int'(s) * int'(pos_weight)) % int'(SYM_MODULUS);
         chk_sum    = 7'(acc);
         pos_weight = 7'((int'(pos_weight) + 1) % int'(SYM_MODULUS));
      end
      push_pattern({2'b00, SYM_TABLE[s]}, int'(SYM_LEN));
      if (last) begin
         push_pattern({2'b00, SYM_TABLE[chk_sum]}, int'(SYM_LEN));
         push_pattern(STOP_PATTERN, int'(STOP_LEN));
         push_pattern(13'd0, QUIET);
         chk_sum    = 7'd0;
         pos_weight = 7'd0;
      end
      beat         = module_q.pop_back();
      beat.end_run = 1'b1;
      module_q.push_back(beat);
   endfunction

   // prediction and checking, both on the accepting edge
   always @(posedge clock) begin
      module_beat_type exp_beat;
      int              exp_len;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expand_symbol(req_symbol, req_first, req_last);
         end
         if (rsp_valid && !rsp_stall) begin
            if (module_q.size() == 0) begin
               note_mismatch($sformatf("expected no module, got module %0b end %0b",
                                       rsp_module_res, rsp_end_of_run));
            end else begin
               exp_beat = module_q.pop_front();
               if (exp_beat.bar_space !== rsp_module_res ||
                   exp_beat.end_run !== rsp_end_of_run) begin
                  note_mismatch($sformatf("expected module %0b end %0b, got %0b end %0b",
                                          exp_beat.bar_space, exp_beat.end_run,
                                          rsp_module_res, rsp_end_of_run));
               end
            end
            beats_in_run++;
            if (rsp_end_of_run === 1'b1) begin
               if (run_len_q.size() != 0) begin
                  exp_len = run_len_q.pop_front();
                  if (exp_len != 0 && exp_len != beats_in_run) begin
                     note_mismatch($sformatf("expected %0d modules in transaction, got %0d",
                                             exp_len, beats_in_run));
                  end
               end
               beats_in_run = 0;
            end
         end
      end
   end

   // output side stall, with an optional long hold
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCH_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   task automatic send_item(input logic [6:0] sym, input logic first, input logic last,
                            input int run_len);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      run_len_q.push_back(run_len);
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_first  <= first;
      req_last   <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // mostly well-formed barcodes, some stray transactions and missing ends
   task automatic send_barcode();
      logic [6:0] start_sym;
      logic [6:0] s;
      int         n_data;
      bit         drop_last;
      if ($urandom_range(0, 5) == 0) begin
         send_item(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 0);
         return;
      end
      if ($urandom_range(0, 7) == 0) begin
         start_sym = 7'($urandom_range(0, 127));
      end else begin
         start_sym = 7'(103 + $urandom_range(0, 2));
      end
      n_data    = $urandom_range(0, 8);
      drop_last = ($urandom_range(0, 9) == 0);
      send_item(start_sym, 1'b1, (n_data == 0) && !drop_last, 0);
      for (int k = 1; k <= n_data; k++) begin
         if ($urandom_range(0, 7) == 0) begin
            s = 7'($urandom_range(0, 127));
         end else begin
            s = 7'($urandom_range(0, 102));
         end
         send_item(s, 1'b0, (k == n_data) && !drop_last, 0);
      end
   endtask

   initial begin
      int phase_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_item(DIRECTED[i].sym, DIRECTED[i].first, DIRECTED[i].last,
                   int'(DIRECTED[i].run_len));
      end

      // long barcode so the position weight wraps
      send_item(7'd104, 1'b1, 1'b0, 21);
      for (int k = 1; k <= 108; k++) begin
         send_item(7'($urandom_range(0, 102)), 1'b0, k == 108, 0);
      end

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               hold_req      = 1'b1;
            end
            1: begin
               send_idle_pct = 79;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 79;
            end
            default: begin
               send_idle_pct = 28;
               rsp_stall_pct = 28;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_barcode();
         end
      end
      req_valid <= 1'b0;

      while (module_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (module_q.size() != 0) begin
         note_mismatch($sformatf("%0d modules never arrived", module_q.size()));
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
